[src/kwhd_pkg.sv]
// ----------------------------------------------------------------------------
// kwhd_pkg
// Types, key codes and the character map shared by the hex id decoder files.
// ----------------------------------------------------------------------------
package kwhd_pkg;

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        key_code;
    logic signed [31:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       char_valid;
    logic       last_char;
    logic [5:0] terminator_code;
  } out_item_t;

  // Push request from the front end into the result queue.
  typedef struct packed {
    logic      push;
    out_item_t item;
  } q_push_t;

  localparam logic [15:0] KEY_ENVELOPE = 16'd42;
  localparam logic [15:0] KEY_END_MARK = 16'd53;
  localparam logic [15:0] KEY_SHIFT    = 16'd54;
  localparam logic [15:0] KEY_TERM_D   = 16'd32;
  localparam logic [15:0] KEY_TERM_C   = 16'd46;
  localparam logic [15:0] KEY_DIGIT_1  = 16'd2;
  localparam logic [15:0] KEY_DIGIT_0  = 16'd11;
  localparam logic [15:0] KEY_HEX_A    = 16'd30;
  localparam logic [15:0] KEY_HEX_B    = 16'd48;
  localparam logic [15:0] KEY_HEX_E    = 16'd18;
  localparam logic [15:0] KEY_HEX_F    = 16'd33;

  localparam logic [31:0] VAL_PRESS = 32'd1;

  // Maps a key code to its ASCII hex character; zero means no character.
  function automatic logic [7:0] hex_char(input logic [15:0] code, input logic shifted);
    logic [7:0] base;
    logic [7:0] ch;
    base = shifted ? 8'h41 : 8'h61;
    ch   = 8'h00;
    if (!shifted && code >= KEY_DIGIT_1 && code <= KEY_DIGIT_0) begin
      if (code == KEY_DIGIT_0) begin
        ch = 8'h30;
      end else begin
        ch = code[7:0] + 8'h2F;
      end
    end else begin
      case (code)
        KEY_HEX_A:  ch = base;
        KEY_HEX_B:  ch = base + 8'd1;
        KEY_TERM_C: ch = base + 8'd2;
        KEY_TERM_D: ch = base + 8'd3;
        KEY_HEX_E:  ch = base + 8'd4;
        KEY_HEX_F:  ch = base + 8'd5;
        default:    ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

[src/kwhd_front.sv]
// ----------------------------------------------------------------------------
// kwhd_front
// Accepts key events, tracks envelope, shift and end mark, stores the id and
// sequences the stored characters into the result queue.
// ----------------------------------------------------------------------------
module kwhd_front
  import kwhd_pkg::*;
#(
  parameter int MAX_CHARS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output q_push_t  q_req,
  input  logic     q_full
);

  localparam int CNT_W = $clog2(MAX_CHARS + 1);
  localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_EMIT    = 2'd1;
  localparam logic [1:0] ST_DRAIN   = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             shift_r, shift_nxt;
  logic             end_seen_r, end_seen_nxt;
  logic             env_open_r, env_open_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [5:0]       term_r, term_nxt;
  logic [7:0]       store_r [MAX_CHARS];

  logic       accept;
  logic       nonzero;
  logic       press;
  logic [7:0] new_char;
  logic       store_we;
  logic       last_item;

  assign in_stall = (state_r == ST_EMIT);
  assign accept   = in_valid && !in_stall;
  assign nonzero  = (in_data.key_value != 32'sd0);
  assign press    = (in_data.key_value == $signed(VAL_PRESS));
  assign new_char = hex_char(in_data.key_code, shift_r);
  assign last_item = (count_r == '0) || (pos_r + CNT_W'(1) == count_r);

  always_comb begin
    state_nxt    = state_r;
    shift_nxt    = shift_r;
    end_seen_nxt = end_seen_r;
    env_open_nxt = env_open_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    term_nxt     = term_r;
    store_we     = 1'b0;
    q_req        = '0;

    case (state_r)
      ST_COLLECT: begin
        if (accept) begin
          if (in_data.key_code == KEY_ENVELOPE) begin
            env_open_nxt = nonzero;
          end else if (end_seen_r) begin
            if ((in_data.key_code == KEY_TERM_D || in_data.key_code == KEY_TERM_C)
                && press) begin
              state_nxt = ST_EMIT;
              pos_nxt   = '0;
              term_nxt  = in_data.key_code[5:0];
            end
          end else if (env_open_r && in_data.key_code == KEY_END_MARK) begin
            end_seen_nxt = nonzero;
            env_open_nxt = 1'b0;
          end else if (in_data.key_code == KEY_SHIFT) begin
            shift_nxt = nonzero;
          end else if (press && !env_open_r) begin
            if (new_char != 8'h00 && count_r < CNT_MAX) begin
              store_we  = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
      end
      ST_EMIT: begin
        q_req.item.char_valid      = (count_r != '0);
        q_req.item.char_byte       = (count_r != '0) ? store_r[pos_r[IDX_W-1:0]] : 8'h00;
        q_req.item.last_char       = last_item;
        q_req.item.terminator_code = term_r;
        if (!q_full) begin
          q_req.push = 1'b1;
          if (last_item) begin
            state_nxt = ST_DRAIN;
          end else begin
            pos_nxt = pos_r + CNT_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (accept && in_data.event_type == 16'd0 && in_data.key_code == 16'd0
            && in_data.key_value == 32'sd0) begin
          state_nxt    = ST_COLLECT;
          shift_nxt    = 1'b0;
          end_seen_nxt = 1'b0;
          env_open_nxt = 1'b0;
          count_nxt    = '0;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_COLLECT;
      shift_r    <= 1'b0;
      end_seen_r <= 1'b0;
      env_open_r <= 1'b0;
      count_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      shift_r    <= shift_nxt;
      end_seen_r <= end_seen_nxt;
      env_open_r <= env_open_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    term_r <= term_nxt;
    if (store_we) begin
      store_r[count_r[IDX_W-1:0]] <= new_char;
    end
  end

endmodule

[src/kwhd_queue.sv]
// ----------------------------------------------------------------------------
// kwhd_queue
// Result queue and output stage; its head drives the result channel.
// ----------------------------------------------------------------------------
module kwhd_queue
  import kwhd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_push_t   q_req,
  output logic      q_full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  out_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] level_r, level_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_full    = (level_r == CNT_FULL);
  assign out_valid = (level_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign do_push   = q_req.push && !q_full;
  assign do_pop    = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_req.item;
    end
  end

endmodule

[src/keyboard_wedge_hex_id_decoder.sv]
// ----------------------------------------------------------------------------
// keyboard_wedge_hex_id_decoder
// Decodes a hex identifier typed through a keyboard-style event stream.
// ----------------------------------------------------------------------------
// Key events enter on the in_ channel (valid/stall) as one transaction each,
// and the decoded id leaves on the out_ channel, one character per
// transaction, with the last one flagged and the terminating key code.
// Ordinary events are taken one per cycle and give no result. A terminator
// press starts the emitter: it moves one stored character per cycle, while
// the queue has room, into a small result queue, and in_stall stays high
// until the last one (or the single empty-id result) has been pushed.
// The first result shows on out_valid once the emitter, entered on the
// accepted terminator, has written it into the queue registers;
// later ones follow one per cycle while the receiver takes them.
// The emitter read port on the character store sets this one-per-cycle rate.
// A stall on the out_ side only fills the queue. While the queue is full the
// emitter waits and in_stall stays high for those extra cycles; outside
// emission the input never waits on the out_ side. After the id is sent the
// block drops every event until a sync event of all zeros, which clears it.
// Reset (rst_n low, synchronous) clears all flags, the character count and
// the queue; the character store itself needs no clearing.
// ----------------------------------------------------------------------------
module keyboard_wedge_hex_id_decoder
  import kwhd_pkg::*;
#(
  parameter int MAX_CHARS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Push requests from the front end and back-pressure from the queue.
  q_push_t q_req;
  logic    q_full;

  kwhd_front #(
    .MAX_CHARS(MAX_CHARS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_req    (q_req),
    .q_full   (q_full)
  );

  kwhd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_req     (q_req),
    .q_full    (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[src/kwhd_checker.sv]
// ----------------------------------------------------------------------------
// kwhd_checker
// Port-level checks for the hex id decoder, bound to the top level.
// ----------------------------------------------------------------------------
module kwhd_checker
  import kwhd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled input transaction holds.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Characters of one id follow without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_char |=> out_valid)
    else $error("gap inside an id");

  // An empty id is a single, final result.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.char_valid |-> out_data.last_char)
    else $error("empty result not marked last");

  // Only the two terminator keys end an id.
  a_term_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.terminator_code == KEY_TERM_D[5:0]
                   || out_data.terminator_code == KEY_TERM_C[5:0]))
    else $error("bad terminator code");

endmodule

bind keyboard_wedge_hex_id_decoder kwhd_checker u_kwhd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/keyboard_wedge_hex_id_decoder_tb.sv]
// ----------------------------------------------------------------------------
// keyboard_wedge_hex_id_decoder_tb
// Self-checking testbench for the keyboard-style hex id decoder.
// ----------------------------------------------------------------------------
// Key events are driven as input transactions, and each one the block accepts
// is fed to a scoreboard. The scoreboard keeps its own model of the decoder
// and queues the characters that a terminator press should produce. Every
// result transaction is checked field by field against the oldest queued
// character. The stimulus starts with a short directed part (empty id,
// overlong id, shift, repeats, releases, draining) and goes on with random
// ids, most of them well formed, mixed with noise and broken sequences.
// Both sides idle in random bursts, and one long receiver hold-off makes the
// result queue fill so that the block stalls its input.
// ----------------------------------------------------------------------------
module keyboard_wedge_hex_id_decoder_tb
  import kwhd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_CHARS     = 16;
  localparam int RANDOM_ITEMS = 200;
  localparam int CALM_ITEMS   = 170;    // No idling on either side past this count.
  localparam int LONG_HOLD    = 120;
  localparam int SETTLE       = 16;
  localparam int LIMIT_CYCLES = 200000;

  // Event types and values used by the stimulus.
  localparam logic [15:0] EV_SYNC     = 16'd0;
  localparam logic [15:0] EV_KEY      = 16'd1;
  localparam logic [15:0] KEY_NONE    = 16'd0;
  localparam logic [31:0] VAL_RELEASE = 32'd0;
  localparam logic [31:0] VAL_REPEAT  = 32'd2;

  localparam logic [7:0] ASCII_0       = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;

  // --------------------------------------------------------------------------
  // Scoreboard: models the decoder on every accepted event and holds the
  // characters that are still to come out of the block.
  // --------------------------------------------------------------------------
  class id_scoreboard;
    bit          shift_held;
    bit          end_seen;
    bit          env_open;
    bit          draining;
    logic [7:0]  id_chars[ID_CHARS];
    int unsigned n_chars;
    out_item_t   pending_chars[$];
    int unsigned errors;

    function void clear_id();
      shift_held = 1'b0;
      end_seen   = 1'b0;
      env_open   = 1'b0;
      draining   = 1'b0;
      n_chars    = 0;
    endfunction

    function logic [7:0] key_to_hex(logic [15:0] code, bit shifted);
      logic [7:0] letter_base;
      letter_base = shifted ? ASCII_UPPER_A : ASCII_LOWER_A;
      if (!shifted && code >= KEY_DIGIT_1 && code <= KEY_DIGIT_0) begin
        if (code == KEY_DIGIT_0) begin
          return ASCII_0;
        end
        return ASCII_0 + (code[7:0] - 8'd1);
      end
      case (code)
        KEY_HEX_A:  return letter_base;
        KEY_HEX_B:  return letter_base + 8'd1;
        KEY_TERM_C: return letter_base + 8'd2;
        KEY_TERM_D: return letter_base + 8'd3;
        KEY_HEX_E:  return letter_base + 8'd4;
        KEY_HEX_F:  return letter_base + 8'd5;
        default:    return 8'h00;
      endcase
    endfunction

    function void note_event(in_item_t ev);
      bit         is_set;
      bit         is_press;
      logic [7:0] ch;
      out_item_t  res;
      is_set   = (ev.key_value != 0);
      is_press = ($unsigned(ev.key_value) == VAL_PRESS);
      if (draining) begin
        if (ev.event_type == EV_SYNC && ev.key_code == KEY_NONE && ev.key_value == 0) begin
          clear_id();
        end
        return;
      end
      if (ev.key_code == KEY_ENVELOPE) begin
        env_open = is_set;
      end else if (end_seen) begin
        if ((ev.key_code == KEY_TERM_D || ev.key_code == KEY_TERM_C) && is_press) begin
          draining = 1'b1;
          res.terminator_code = ev.key_code[5:0];
          if (n_chars == 0) begin
            res.char_byte  = 8'h00;
            res.char_valid = 1'b0;
            res.last_char  = 1'b1;
            pending_chars.push_back(res);
          end else begin
            for (int k = 0; k < n_chars; k++) begin
              res.char_byte  = id_chars[k];
              res.char_valid = 1'b1;
              res.last_char  = (k + 1 == n_chars);
              pending_chars.push_back(res);
            end
          end
        end
      end else if (env_open && ev.key_code == KEY_END_MARK) begin
        end_seen = is_set;
        env_open = 1'b0;
      end else if (ev.key_code == KEY_SHIFT) begin
        shift_held = is_set;
      end else if (is_press && !env_open) begin
        ch = key_to_hex(ev.key_code, shift_held);
        if (ch != 8'h00 && n_chars < ID_CHARS) begin
          id_chars[n_chars] = ch;
          n_chars++;
        end
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_chars.pop_front();
      if (got.char_byte !== want.char_byte) begin
        report_mismatch($sformatf("char_byte %h, expected %h", got.char_byte, want.char_byte));
      end
      if (got.char_valid !== want.char_valid) begin
        report_mismatch($sformatf("char_valid %b, expected %b",
                                  got.char_valid, want.char_valid));
      end
      if (got.last_char !== want.last_char) begin
        report_mismatch($sformatf("last_char %b, expected %b", got.last_char, want.last_char));
      end
      if (got.terminator_code !== want.terminator_code) begin
        report_mismatch($sformatf("terminator_code %0d, expected %0d",
                                  got.terminator_code, want.terminator_code));
      end
    endtask

    task check_leftover();
      if (pending_chars.size() != 0) begin
        report_mismatch($sformatf("%0d expected results never arrived", pending_chars.size()));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test.
  // --------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  id_scoreboard sb = new();

  // Idling switches, set by the stimulus, and the request for one long
  // receiver hold-off while the block is emitting an id.
  bit          tx_idle_on    = 1'b1;
  bit          rx_idle_on    = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned sent_count    = 0;
  int unsigned cycle_count   = 0;

  keyboard_wedge_hex_id_decoder #(
    .MAX_CHARS(ID_CHARS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Both channels are observed at the rising edge, where the block itself
  // samples them, so a transaction is seen exactly when the block takes it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_event(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
    end
  end

  // Watchdog: a run that has not ended by the limit has hung.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: stalls in random bursts, and once holds off for a long stretch
  // so the small result queue fills and the block has to stall its input.
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Inputs change only at the falling edge; each task returns
  // at the rising edge that accepted the transaction.
  // --------------------------------------------------------------------------
  task idle_gap();
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk);
    end
  endtask

  task send_event(logic [15:0] ev_type, logic [15:0] code, logic [31:0] value);
    idle_gap();
    @(negedge clk);
    in_valid           <= 1'b1;
    in_data.event_type <= ev_type;
    in_data.key_code   <= code;
    in_data.key_value  <= value;
    do begin
      @(posedge clk);
    end while (in_stall);
    sent_count++;
  endtask

  // Any 32-bit value other than zero, so a held flag is set.
  function automatic logic [31:0] any_nonzero();
    logic [31:0] v;
    v = $urandom;
    return (v == 32'd0) ? VAL_PRESS : v;
  endfunction

  // One of the sixteen keys that map to a hex character.
  function automatic logic [15:0] any_hex_key();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 10) begin
      return KEY_DIGIT_1 + 16'(pick);
    end
    case (pick)
      10:      return KEY_HEX_A;
      11:      return KEY_HEX_B;
      12:      return KEY_TERM_C;
      13:      return KEY_TERM_D;
      14:      return KEY_HEX_E;
      default: return KEY_HEX_F;
    endcase
  endfunction

  task send_noise();
    send_event(16'($urandom), 16'($urandom), $urandom);
  endtask

  // A press, often followed by its release.
  task tap_key(logic [15:0] code);
    send_event(EV_KEY, code, VAL_PRESS);
    if ($urandom_range(0, 1) == 0) begin
      send_event(EV_KEY, code, VAL_RELEASE);
    end
  endtask

  // Marks the end of the id: open the envelope, then set the end mark.
  task close_id(logic [31:0] mark);
    send_event(EV_KEY, KEY_ENVELOPE, any_nonzero());
    send_event(EV_KEY, KEY_END_MARK, mark);
  endtask

  task drain_and_sync();
    repeat ($urandom_range(0, 3)) send_noise();
    if ($urandom_range(0, 3) == 0) begin
      // Almost a sync event: still dropped.
      send_event(EV_KEY, KEY_NONE, VAL_RELEASE);
    end
    send_event(EV_SYNC, KEY_NONE, VAL_RELEASE);
  endtask

  // One random id. Most are well formed; some leave out the end mark or the
  // terminator, so the next id runs into the state they leave behind.
  task random_id();
    int unsigned n_keys;
    int unsigned shape;
    n_keys = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 6);
    for (int i = 0; i < n_keys; i++) begin
      case ($urandom_range(0, 9))
        0: send_event(EV_KEY, KEY_SHIFT, ($urandom_range(0, 1) == 0) ? VAL_RELEASE
                                                                      : any_nonzero());
        1: send_noise();
        2: begin
          // Keys typed inside the envelope are not part of the id.
          send_event(EV_KEY, KEY_ENVELOPE, VAL_PRESS);
          send_event(EV_KEY, any_hex_key(), VAL_PRESS);
          send_event(EV_KEY, KEY_ENVELOPE, VAL_RELEASE);
        end
        3: send_event(EV_KEY, any_hex_key(), VAL_REPEAT);
        default: ;
      endcase
      tap_key(any_hex_key());
    end
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      // End mark cleared instead of set: the id keeps growing.
      close_id(VAL_RELEASE);
      return;
    end
    if (shape == 1) begin
      // End mark key outside the envelope does nothing.
      send_event(EV_KEY, KEY_END_MARK, VAL_PRESS);
    end
    close_id(any_nonzero());
    if (shape == 2) begin
      // Events ignored once the end mark is set.
      send_event(EV_KEY, KEY_SHIFT, VAL_PRESS);
      send_event(EV_KEY, any_hex_key(), VAL_PRESS);
      send_event(EV_KEY, KEY_TERM_D, VAL_REPEAT);
    end
    if (shape == 3) begin
      return;
    end
    send_event(EV_KEY, ($urandom_range(0, 1) == 0) ? KEY_TERM_D : KEY_TERM_C, VAL_PRESS);
    drain_and_sync();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty id: a single result without a character. The draining phase
    // then drops an all-ones event before the sync clears the block.
    close_id(VAL_PRESS);
    send_event(EV_KEY, KEY_TERM_D, VAL_PRESS);
    send_event(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(EV_SYNC, KEY_NONE, VAL_RELEASE);

    // Overlong id. Shift held by the most negative value gives an upper case
    // letter, and a digit under shift gives nothing; repeats and releases
    // append nothing. Sixteen characters are kept, the seventeenth dropped.
    send_event(EV_KEY, KEY_SHIFT, 32'h8000_0000);
    send_event(EV_KEY, KEY_HEX_A, VAL_PRESS);
    send_event(EV_KEY, KEY_HEX_A, VAL_REPEAT);
    send_event(EV_KEY, KEY_HEX_A, VAL_RELEASE);
    send_event(EV_KEY, KEY_DIGIT_1, VAL_PRESS);
    send_event(16'hFFFF, KEY_SHIFT, VAL_RELEASE);
    for (logic [15:0] code = KEY_DIGIT_1; code <= KEY_DIGIT_0; code++) begin
      send_event(EV_KEY, code, VAL_PRESS);
    end
    send_event(EV_KEY, KEY_HEX_B, VAL_PRESS);
    send_event(EV_KEY, KEY_TERM_C, VAL_PRESS);
    send_event(EV_KEY, KEY_TERM_D, VAL_PRESS);
    send_event(EV_KEY, KEY_HEX_E, VAL_PRESS);
    send_event(EV_KEY, KEY_HEX_F, VAL_PRESS);
    send_event(EV_KEY, KEY_HEX_F, VAL_PRESS);
    close_id(32'h7FFF_FFFF);

    // The receiver holds off as the sixteen characters start to come out, and
    // the sender keeps offering transactions into the stalled input.
    long_hold_req = 1'b1;
    send_event(EV_KEY, KEY_TERM_C, VAL_PRESS);
    repeat (8) send_noise();
    send_event(EV_SYNC, KEY_NONE, VAL_RELEASE);

    // Random ids; idling is switched per id and turned off near the end.
    while (sent_count < RANDOM_ITEMS) begin
      if (sent_count > CALM_ITEMS) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      random_id();
    end

    // Finish any id left open so its characters come out too.
    close_id(VAL_PRESS);
    send_event(EV_KEY, KEY_TERM_D, VAL_PRESS);
    send_event(EV_SYNC, KEY_NONE, VAL_RELEASE);
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
    sb.check_leftover();

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
